// File: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types, sizes and word helpers for the ring-buffer double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = ((AW > 8) ? AW : 8) + 2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4
    } t_deq_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_deq_status;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
        logic [7:0]         position;
    } t_deq_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [8:0]         element_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_deq_out;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [AW-1:0]         addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_deq_mem_req;

    typedef struct packed {
        logic             valid;
        logic             use_rdata;
        t_deq_status      status;
        logic [CNT_W-1:0] count;
    } t_deq_rsp;

    function automatic logic [DATA_WIDTH-1:0] word_in(logic signed [31:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [31:0] word_out(logic [DATA_WIDTH-1:0] w);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           t;
        s = w;
        t = 64'(s);
        return t[31:0];
    endfunction

    function automatic logic [8:0] count_field(logic [CNT_W-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[8:0];
    endfunction

endpackage

// File: rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH_P = 256,
    parameter int WIDTH_P = 32,
    parameter int ADDR_P  = 8
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic               i_re,
    input  logic [ADDR_P-1:0]  i_addr,
    input  logic [WIDTH_P-1:0] i_wdata,
    output logic [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

// File: rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Front pointer and count; decodes an operation into a slot access.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  deq_pkg::t_deq_in      i_op,
    output deq_pkg::t_deq_mem_req o_mem,
    output deq_pkg::t_deq_rsp     o_rsp
);
    import deq_pkg::*;

    logic [AW-1:0]    r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    t_deq_rsp         r_rsp, n_rsp;

    logic [SUM_W-1:0] offset;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    logic [AW-1:0]    front_dec;
    logic [AW-1:0]    front_inc;
    logic             full;
    logic             empty;
    logic             in_range;

    assign full     = (SUM_W'(r_count) == SUM_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign in_range = (SUM_W'(i_op.position) < SUM_W'(r_count));

    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (SUM_W'(r_front) == SUM_W'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    always_comb begin
        case (i_op.opcode)
            OP_PUSH_BACK: offset = SUM_W'(r_count);
            OP_POP_BACK:  offset = SUM_W'(r_count) - SUM_W'(1);
            OP_READ_AT:   offset = SUM_W'(i_op.position);
            default:      offset = '0;
        endcase
        sum     = SUM_W'(r_front) + offset;
        wrapped = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
    end

    always_comb begin
        n_front         = r_front;
        n_count         = r_count;
        n_rsp.valid     = i_accept;
        n_rsp.use_rdata = 1'b0;
        n_rsp.status    = ST_OK;
        o_mem.we        = 1'b0;
        o_mem.re        = 1'b0;
        o_mem.addr      = wrapped[AW-1:0];
        o_mem.wdata     = word_in(i_op.push_value);
        case (i_op.opcode)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    o_mem.we   = i_accept;
                    o_mem.addr = front_dec;
                    n_front    = front_dec;
                    n_count    = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    o_mem.we = i_accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    o_mem.re        = i_accept;
                    o_mem.addr      = r_front;
                    n_rsp.use_rdata = 1'b1;
                    n_front         = front_inc;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    o_mem.re        = i_accept;
                    n_rsp.use_rdata = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            OP_READ_AT: begin
                if (!in_range) begin
                    n_rsp.status = ST_RANGE;
                end else begin
                    o_mem.re        = i_accept;
                    n_rsp.use_rdata = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_rsp.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_rsp.valid <= 1'b0;
        end else begin
            r_rsp.valid <= n_rsp.valid;
            if (i_accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
        end
        if (i_accept) begin
            r_rsp.use_rdata <= n_rsp.use_rdata;
            r_rsp.status    <= n_rsp.status;
            r_rsp.count     <= n_rsp.count;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring-buffer RAM.
//
//   channel   ports                      transfer
//   command   i_start, o_busy, i_op      i_start high, o_busy low
//   result    o_done, o_result           o_done high for one cycle
//
// One operation per cycle. The result of an operation accepted at one edge
// appears in the following cycle, from the registered RAM read data. o_busy stays low:
// each operation touches one slot and the RAM reads before any later write.
// Synchronous active-low reset empties the queue; slot contents are
// undefined until pushed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  deq_pkg::t_deq_in   i_op,
    output logic               o_done,
    output deq_pkg::t_deq_out  o_result
);
    import deq_pkg::*;

    t_deq_mem_req          mem_req;
    t_deq_rsp              rsp;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .o_mem    (mem_req),
        .o_rsp    (rsp)
    );

    deq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_WIDTH),
        .ADDR_P  (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (rdata)
    );

    assign o_done                 = rsp.valid;
    assign o_result.read_value    = rsp.use_rdata ? word_out(rdata) : 32'sd0;
    assign o_result.element_count = count_field(rsp.count);
    assign o_result.is_empty      = (rsp.count == '0);
    assign o_result.status        = rsp.status;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring-buffer double-ended queue. A scripted run
// of pushes, pops and indexed reads goes through a command driver with random
// idle bursts. Each transfer is mirrored in a software deque, and every strobed
// result is compared field by field against the mirrored outcome.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         RANDOM_OPS  = 1250;
    localparam int         QUIET_TAIL  = 150;
    localparam int         STALL_LIMIT = 2000;

    typedef struct packed {
        logic    hold;
        t_deq_in op;
    } t_stim;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_deq_in   i_op    = '0;
    logic      o_busy;
    logic      o_done;
    t_deq_out  o_result;

    t_stim     op_queue[$];
    t_deq_out  reply_queue[$];

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [AW-1:0]         ring_head = '0;
    int                    ring_fill = 0;
    int                    gen_fill  = 0;
    int                    n_added   = 0;
    int                    gap_left  = 0;
    int                    idle_run  = 0;
    int                    n_sent    = 0;
    int                    n_checked = 0;
    int                    n_errors  = 0;
    int                    n_full    = 0;
    int                    n_underrun = 0;
    int                    n_range   = 0;
    int                    peak_fill = 0;

    double_ended_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_op     (i_op),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_deq_out model_deque_op(t_deq_in op);
        t_deq_out r;
        logic [AW-1:0] slot;
        r = '0;
        r.status = ST_OK;
        case (op.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (ring_fill >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    if (op.opcode == OP_PUSH_FRONT) begin
                        ring_head = ring_head - 1'b1;
                        slot = ring_head;
                    end else begin
                        slot = ring_head + AW'(ring_fill);
                    end
                    ring_mem[slot] = op.push_value;
                    ring_fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                    n_underrun++;
                end else begin
                    if (op.opcode == OP_POP_FRONT) begin
                        slot = ring_head;
                        ring_head = ring_head + 1'b1;
                    end else begin
                        slot = ring_head + AW'(ring_fill - 1);
                    end
                    r.read_value = ring_mem[slot];
                    ring_fill--;
                end
            end
            OP_READ_AT: begin
                if (int'(op.position) >= ring_fill) begin
                    r.status = ST_RANGE;
                    n_range++;
                end else begin
                    slot = ring_head + AW'(op.position);
                    r.read_value = ring_mem[slot];
                end
            end
            default: ;
        endcase
        if (ring_fill > peak_fill) peak_fill = ring_fill;
        r.element_count = 9'(ring_fill);
        r.is_empty      = (ring_fill == 0);
        return r;
    endfunction

    task automatic add_op(input logic [2:0] code, input logic [31:0] value,
                          input logic [7:0] pos);
        t_stim s;
        s.hold            = 1'b0;
        s.op.opcode       = code;
        s.op.push_value   = value;
        s.op.position     = pos;
        op_queue.push_back(s);
        n_added++;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_fill < DEPTH) gen_fill++;
            OP_POP_FRONT, OP_POP_BACK:   if (gen_fill > 0) gen_fill--;
            default: ;
        endcase
    endtask

    task automatic add_hold();
        t_stim s;
        s      = '0;
        s.hold = 1'b1;
        op_queue.push_back(s);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_pos();
        if (gen_fill == 0 || $urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, gen_fill - 1));
    endfunction

    function automatic logic [2:0] push_end();
        return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pop_end();
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // driver: advance through the stimulus queue, hold on hold-off markers
    always @(posedge i_clk) begin : driver
        logic    start_nxt;
        t_deq_in op_nxt;
        t_stim   head;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                reply_queue.push_back(model_deque_op(i_op));
                n_sent++;
            end
            start_nxt = i_start && o_busy;
            op_nxt    = i_op;
            if (!start_nxt) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (op_queue.size() != 0) begin
                    if (op_queue[0].hold) begin
                        if (reply_queue.size() == 0 && !o_done) begin
                            void'(op_queue.pop_front());
                        end
                    end else if (op_queue.size() > QUIET_TAIL && $urandom_range(0, 99) < 6) begin
                        gap_left = $urandom_range(1, 15) - 1;
                    end else begin
                        head      = op_queue.pop_front();
                        op_nxt    = head.op;
                        start_nxt = 1'b1;
                    end
                end
            end
            i_start <= start_nxt;
            i_op    <= op_nxt;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_deq_out want;
        if (i_rst_n && o_done) begin
            if (reply_queue.size() == 0) begin
                $error("result strobed with no operation outstanding");
                n_errors++;
            end else begin
                want = reply_queue.pop_front();
                n_checked++;
                if (o_result.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, o_result.read_value);
                    n_errors++;
                end
                if (o_result.element_count !== want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, o_result.element_count);
                    n_errors++;
                end
                if (o_result.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0b, got %0b",
                           want.is_empty, o_result.is_empty);
                    n_errors++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** double_ended_queue: FAILED **");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin : stimulus
        int c;
        int mode;
        int len;
        int r;
        int directed;

        // empty queue corner cases, then directed pushes, indexed reads and pops
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_POP_BACK, '0, '0);
        add_op(OP_READ_AT, '0, 8'd0);
        add_op(OP_READ_AT, '0, 8'd255);
        for (c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) add_op(c[2:0], '1, '1);
        add_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, '0);
        add_op(OP_PUSH_BACK, 32'h8000_0000, '1);
        add_op(OP_PUSH_FRONT, 32'h0000_0000, '0);
        add_op(OP_PUSH_BACK, 32'hFFFF_FFFF, '0);
        add_op(OP_PUSH_FRONT, 32'h0000_0001, '0);
        add_op(OP_READ_AT, '0, 8'd0);
        add_op(OP_READ_AT, '0, 8'd4);
        add_op(OP_READ_AT, '0, 8'd5);
        add_op(OP_READ_AT, '0, 8'd255);
        add_op(OP_SPARE_HI, 32'h1234_5678, 8'd3);
        add_op(OP_POP_BACK, '0, '0);
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_POP_BACK, '0, '0);
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_POP_BACK, '0, '0);
        add_op(OP_POP_FRONT, '0, '0);
        add_op(OP_PUSH_BACK, 32'h5A5A_A5A5, '0);
        add_hold();
        directed = n_added;

        while (n_added - directed < RANDOM_OPS) begin
            mode = (n_added == directed) ? 0 : $urandom_range(0, 2);
            case (mode)
                0: begin
                    while (gen_fill < DEPTH) begin
                        r = $urandom_range(0, 99);
                        if (r < 80)      add_op(push_end(), rand_word(), pick_pos());
                        else if (r < 95) add_op(OP_READ_AT, rand_word(), pick_pos());
                        else             add_op(pop_end(), rand_word(), pick_pos());
                    end
                    repeat ($urandom_range(2, 6)) add_op(push_end(), rand_word(), pick_pos());
                    add_op(OP_READ_AT, rand_word(), 8'd255);
                    add_op(OP_READ_AT, rand_word(), pick_pos());
                end
                1: begin
                    while (gen_fill > 0) begin
                        r = $urandom_range(0, 99);
                        if (r < 75)      add_op(pop_end(), rand_word(), pick_pos());
                        else if (r < 90) add_op(OP_READ_AT, rand_word(), pick_pos());
                        else if (r < 97) add_op(push_end(), rand_word(), pick_pos());
                        else             add_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                                rand_word(), pick_pos());
                    end
                    repeat ($urandom_range(2, 5)) add_op(pop_end(), rand_word(), pick_pos());
                    add_op(OP_READ_AT, rand_word(), pick_pos());
                end
                default: begin
                    len = $urandom_range(40, 150);
                    repeat (len) begin
                        r = $urandom_range(0, 99);
                        if (r < 32)      add_op(push_end(), rand_word(), pick_pos());
                        else if (r < 63) add_op(pop_end(), rand_word(), pick_pos());
                        else if (r < 95) add_op(OP_READ_AT, rand_word(), pick_pos());
                        else             add_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                                rand_word(), pick_pos());
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0) add_hold();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || i_start || reply_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (reply_queue.size() != 0) begin
            $error("%0d results never arrived", reply_queue.size());
            n_errors++;
        end

        $display("Ran %0d operations, %0d results checked, peak occupancy %0d of %0d.",
                 n_sent, n_checked, peak_fill, DEPTH);
        $display("Error cases hit: %0d push on full, %0d pop on empty, %0d read out of range.",
                 n_full, n_underrun, n_range);
        if (n_errors == 0) begin
            $display("** double_ended_queue: PASSED **");
        end else begin
            $display("** double_ended_queue: FAILED **");
        end
        $finish;
    end

endmodule

// File: double_ended_queue.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/double_ended_queue.sv
tb/sv/tb_top.sv
